// ===== sv/tpf_pkg.sv =====
// Package for the tilemap pixel fetch block.
// Holds item structs, register codes, status codes and sizing constants.
// No dependencies.
package tpf_pkg;

    localparam int VRAM_BYTES_DEFAULT = 524288;
    localparam int ADDR_W             = 24;
    localparam int OUT_DEPTH          = 4;
    localparam int MID_DEPTH          = 2;
    localparam int LANES              = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_PAGE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HIGH    = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [1:0] STATUS_WRITTEN     = 2'd0;
    localparam logic [1:0] STATUS_TRANSPARENT = 2'd1;
    localparam logic [1:0] STATUS_SKIPPED     = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [18:0] write_address;
        logic [7:0]  write_data;
        logic [8:0]  pixel_x;
        logic [8:0]  pixel_y;
    } req_t;

    typedef struct packed {
        logic [7:0] colour_index;
        logic [1:0] pixel_status;
        logic [8:0] echo_x;
        logic [8:0] echo_y;
    } rsp_t;

    typedef struct packed {
        logic       colour_mode;
        logic [4:0] map_page;
        logic [2:0] map_high;
    } cfg_t;

    typedef struct packed {
        logic              is_write;
        logic              write_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        write_data;
        logic              entry_oob;
        logic [8:0]        pixel_x;
        logic [8:0]        pixel_y;
    } op_t;

endpackage

// ===== sv/tpf_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// Reads return the old contents on a same-cycle write. No dependencies.
module tpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] ra_addr,
    output logic [WIDTH-1:0]         ra_data,
    input  logic [$clog2(DEPTH)-1:0] rb_addr,
    output logic [WIDTH-1:0]         rb_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] ra_data_reg;
    logic [WIDTH-1:0] rb_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        ra_data_reg <= mem_reg[ra_addr];
        rb_data_reg <= mem_reg[rb_addr];
    end

    assign ra_data = ra_data_reg;
    assign rb_data = rb_data_reg;

endmodule

// ===== sv/tpf_fifo.sv =====
// Small register FIFO with simultaneous push and pop.
// Used for the front-to-back queue and the result queue. No dependencies.
module tpf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = data_reg[rd_ptr_reg];
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full fifo");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty fifo");

endmodule

// ===== sv/tpf_front.sv =====
// Front end: classifies request items and queues them for the back end.
// Works out the name table entry address and range checks.
// Depends on tpf_pkg and tpf_fifo.
module tpf_front #(
    parameter int VRAM_BYTES = tpf_pkg::VRAM_BYTES_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tpf_pkg::cfg_t cfg,
    input  logic          req_valid,
    output logic          req_ready,
    input  tpf_pkg::req_t req,
    output logic          op_valid,
    output tpf_pkg::op_t  op,
    input  logic          op_pop
);

    localparam int AW = tpf_pkg::ADDR_W;

    logic [8:0]          page_sum;
    logic [AW-1:0]       entry;
    logic [AW-1:0]       wr_addr_ext;
    tpf_pkg::op_t        op_in;
    logic                q_full;
    logic                q_empty;
    logic [$clog2(tpf_pkg::MID_DEPTH+1)-1:0] q_count;

    always_comb
    begin
        page_sum    = {cfg.map_high, 6'b0} + {4'b0, cfg.map_page};
        entry       = {2'b00, page_sum, 13'b0}
                    + {10'b0, req.pixel_y[8:3], req.pixel_x[8:3], 2'b00};
        wr_addr_ext = {5'b0, req.write_address};

        op_in.is_write   = (req.cmd == tpf_pkg::CMD_WRITE);
        op_in.write_en   = wr_addr_ext < AW'(VRAM_BYTES);
        op_in.addr       = op_in.is_write ? wr_addr_ext : entry;
        op_in.write_data = req.write_data;
        op_in.entry_oob  = (entry + AW'(4)) > AW'(VRAM_BYTES);
        op_in.pixel_x    = req.pixel_x;
        op_in.pixel_y    = req.pixel_y;
    end

    tpf_fifo #(
        .WIDTH ($bits(tpf_pkg::op_t)),
        .DEPTH (tpf_pkg::MID_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (req_valid && req_ready),
        .wr_data (op_in),
        .pop     (op_pop),
        .rd_data (op),
        .full    (q_full),
        .empty   (q_empty),
        .count   (q_count)
    );

    assign req_ready = !q_full;
    assign op_valid  = !q_empty && (q_count != '0);

endmodule

// ===== sv/tpf_back.sv =====
// Back end: video memory in four byte lanes, entry read, character pixel
// read and result queue. Depends on tpf_pkg, tpf_ram and tpf_fifo.
module tpf_back #(
    parameter int VRAM_BYTES = tpf_pkg::VRAM_BYTES_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tpf_pkg::cfg_t cfg,
    input  logic          op_valid,
    input  tpf_pkg::op_t  op,
    output logic          op_pop,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output tpf_pkg::rsp_t rsp
);

    localparam int AW         = tpf_pkg::ADDR_W;
    localparam int LANE_DEPTH = VRAM_BYTES / tpf_pkg::LANES;
    localparam int LANE_AW    = $clog2(LANE_DEPTH);
    localparam int OUT_CW     = $clog2(tpf_pkg::OUT_DEPTH + 1);
    localparam int SUM_W      = OUT_CW + 1;

    logic [7:0]    ra_data [tpf_pkg::LANES];
    logic [7:0]    rb_data [tpf_pkg::LANES];

    logic          s1_valid_reg;
    logic          s1_oob_reg;
    logic [8:0]    s1_x_reg, s1_y_reg;

    logic          s2_valid_reg;
    logic          s2_skip_reg;
    logic [1:0]    s2_lane_reg;
    logic          s2_low_reg;
    logic [3:0]    s2_pal_reg;
    logic          s2_mode_reg;
    logic [8:0]    s2_x_reg, s2_y_reg;

    logic [15:0]   attr, charno;
    logic [AW-1:0] base, size, offset, pix_addr;
    logic          char_oob;
    logic [2:0]    px, py;

    logic [7:0]    pix_byte, pix;
    tpf_pkg::rsp_t out_item;
    logic          out_full, out_empty;
    logic [OUT_CW-1:0] out_count;
    logic          credit_ok;

    assign credit_ok = ({1'b0, out_count} + SUM_W'(s1_valid_reg) + SUM_W'(s2_valid_reg))
                     < SUM_W'(tpf_pkg::OUT_DEPTH);
    assign op_pop    = op_valid && credit_ok;

    for (genvar g = 0; g < tpf_pkg::LANES; g++)
    begin : g_lane
        tpf_ram #(
            .WIDTH (8),
            .DEPTH (LANE_DEPTH)
        ) u_ram (
            .clk     (clk),
            .we      (op_pop && op.is_write && op.write_en && (op.addr[1:0] == 2'(g))),
            .waddr   (op.addr[LANE_AW+1:2]),
            .wdata   (op.write_data),
            .ra_addr (op.addr[LANE_AW+1:2]),
            .ra_data (ra_data[g]),
            .rb_addr (pix_addr[LANE_AW+1:2]),
            .rb_data (rb_data[g])
        );
    end

    always_comb
    begin
        attr     = {ra_data[1], ra_data[0]};
        charno   = {ra_data[3], ra_data[2]};
        base     = cfg.colour_mode ? {2'b0, charno, 6'b0} : {3'b0, charno, 5'b0};
        size     = cfg.colour_mode ? AW'(64) : AW'(32);
        char_oob = (base + size) > AW'(VRAM_BYTES);
        px       = s1_x_reg[2:0] ^ {3{attr[14]}};
        py       = s1_y_reg[2:0] ^ {3{attr[15]}};
        offset   = cfg.colour_mode ? {18'b0, py, px} : {19'b0, py, px[2:1]};
        pix_addr = base + offset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= op_pop && !op.is_write;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_oob_reg  <= op.entry_oob;
        s1_x_reg    <= op.pixel_x;
        s1_y_reg    <= op.pixel_y;
        s2_skip_reg <= s1_oob_reg || char_oob;
        s2_lane_reg <= pix_addr[1:0];
        s2_low_reg  <= px[0];
        s2_pal_reg  <= attr[3:0];
        s2_mode_reg <= cfg.colour_mode;
        s2_x_reg    <= s1_x_reg;
        s2_y_reg    <= s1_y_reg;
    end

    always_comb
    begin
        pix_byte = rb_data[s2_lane_reg];
        if (s2_mode_reg)
        begin
            pix = pix_byte;
        end
        else
        begin
            pix = {4'b0, s2_low_reg ? pix_byte[3:0] : pix_byte[7:4]};
        end
        out_item.echo_x = s2_x_reg;
        out_item.echo_y = s2_y_reg;
        priority if (s2_skip_reg)
        begin
            out_item.pixel_status = tpf_pkg::STATUS_SKIPPED;
            out_item.colour_index = '0;
        end
        else if (pix == '0)
        begin
            out_item.pixel_status = tpf_pkg::STATUS_TRANSPARENT;
            out_item.colour_index = '0;
        end
        else
        begin
            out_item.pixel_status = tpf_pkg::STATUS_WRITTEN;
            out_item.colour_index = s2_mode_reg ? pix : {s2_pal_reg, pix[3:0]};
        end
    end

    tpf_fifo #(
        .WIDTH ($bits(tpf_pkg::rsp_t)),
        .DEPTH (tpf_pkg::OUT_DEPTH)
    ) u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (s2_valid_reg),
        .wr_data (out_item),
        .pop     (rsp_valid && rsp_ready),
        .rd_data (rsp),
        .full    (out_full),
        .empty   (out_empty),
        .count   (out_count)
    );

    assign rsp_valid = !out_empty;

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, out_count} + SUM_W'(s1_valid_reg) + SUM_W'(s2_valid_reg))
            <= SUM_W'(tpf_pkg::OUT_DEPTH))
        else $error("items in flight exceed result queue space");
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> !out_full)
        else $error("result with no queue space");
    a_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && out_item.pixel_status != tpf_pkg::STATUS_WRITTEN)
            |-> out_item.colour_index == '0)
        else $error("non-written pixel carries a colour index");

endmodule

// ===== sv/tilemap_pixel_fetch_core.sv =====
// Throughput: one item per clock unless a full queue stalls; writes and
// fetches mixed in any order. A fetch result is offered after the front
// queue, the name table read, the character byte read on the second read
// port of the four byte-lane video memories and the result queue. Reset
// zeroes the configuration and valid registers and empties both queues;
// video memory is not initialised and holds nothing useful until written.
module tilemap_pixel_fetch_core #(
    parameter int VRAM_BYTES = tpf_pkg::VRAM_BYTES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  tpf_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output tpf_pkg::rsp_t                  rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpf_pkg::CFG_DATA_W-1:0] cfg_data
);

    tpf_pkg::cfg_t cfg_reg, cfg_next;
    logic          op_valid;
    tpf_pkg::op_t  op;
    logic          op_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tpf_pkg::CFG_COLOUR_MODE: cfg_next.colour_mode = cfg_data[0];
                tpf_pkg::CFG_MAP_PAGE:    cfg_next.map_page    = cfg_data[4:0];
                tpf_pkg::CFG_MAP_HIGH:    cfg_next.map_high    = cfg_data[2:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tpf_front #(
        .VRAM_BYTES (VRAM_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .op_valid  (op_valid),
        .op        (op),
        .op_pop    (op_pop)
    );

    tpf_back #(
        .VRAM_BYTES (VRAM_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .op_valid  (op_valid),
        .op        (op),
        .op_pop    (op_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
